>>> src/mk_pkg.sv
// Package for the 256x256 Karatsuba multiplier: operand and product beat types.
// Depends on nothing; used by every file of the block.
package mk_pkg;

    localparam int LIMB_W  = 64;
    localparam int DIGIT_W = 32;
    localparam int HALF_W  = 128;
    localparam int OPER_W  = 256;
    localparam int PROD_W  = 512;

    typedef struct packed {
        logic [LIMB_W-1:0] b_limb3;
        logic [LIMB_W-1:0] b_limb2;
        logic [LIMB_W-1:0] b_limb1;
        logic [LIMB_W-1:0] b_limb0;
        logic [LIMB_W-1:0] a_limb3;
        logic [LIMB_W-1:0] a_limb2;
        logic [LIMB_W-1:0] a_limb1;
        logic [LIMB_W-1:0] a_limb0;
    } operands_t;

    typedef struct packed {
        logic [LIMB_W-1:0] product_limb7;
        logic [LIMB_W-1:0] product_limb6;
        logic [LIMB_W-1:0] product_limb5;
        logic [LIMB_W-1:0] product_limb4;
        logic [LIMB_W-1:0] product_limb3;
        logic [LIMB_W-1:0] product_limb2;
        logic [LIMB_W-1:0] product_limb1;
        logic [LIMB_W-1:0] product_limb0;
    } product_t;

endpackage

>>> src/mk_mul129.sv
// Pipelined 129x129 unsigned multiplier over 32-bit digits, three stages.
// Depends on mk_pkg for digit widths.
module mk_mul129
    import mk_pkg::*;
(
    input  logic                clk,
    input  logic [HALF_W:0]     x,
    input  logic [HALF_W:0]     y,
    output logic [2*HALF_W+1:0] p
);
    localparam int ND = 4;
    localparam int PW = 2*HALF_W + 2;

    // Stage 1: the 16 digit products plus the carry-bit cross terms.
    logic [2*DIGIT_W-1:0] pp_reg [ND*ND];
    logic [PW-1:0]        side_reg;
    // Stage 2: four row sums.
    logic [PW-1:0]        row_reg [ND];

    always_ff @(posedge clk)
    begin
        logic [PW-1:0] s;
        for (int i = 0; i < ND; i++)
        begin
            for (int j = 0; j < ND; j++)
            begin
                pp_reg[i*ND+j] <= (2*DIGIT_W)'(x[i*DIGIT_W +: DIGIT_W])
                                * (2*DIGIT_W)'(y[j*DIGIT_W +: DIGIT_W]);
            end
        end
        s = '0;
        if (x[HALF_W])
            s = s + (PW'(y[HALF_W-1:0]) << HALF_W);
        if (y[HALF_W])
            s = s + (PW'(x[HALF_W-1:0]) << HALF_W);
        if (x[HALF_W] && y[HALF_W])
            s = s + (PW'(1) << (2*HALF_W));
        side_reg <= s;
    end

    always_ff @(posedge clk)
    begin
        logic [PW-1:0] r;
        for (int i = 0; i < ND; i++)
        begin
            r = '0;
            for (int j = 0; j < ND; j++)
            begin
                r = r + (PW'(pp_reg[i*ND+j]) << ((i+j)*DIGIT_W));
            end
            row_reg[i] <= (i == 0) ? r + side_reg : r;
        end
    end

    always_ff @(posedge clk)
    begin
        p <= row_reg[0] + row_reg[1] + row_reg[2] + row_reg[3];
    end
endmodule

>>> src/multiply_256x256_karatsuba.sv
// Usage: 256x256 unsigned multiplier with a full 512-bit product.
// A beat is accepted at a rising edge with start high; busy is always low,
// since the pipeline takes one beat in every cycle.
// Operands come as a packed operands_t, least significant limb first.
// The result strobe done follows acceptance through the stages below and is
// high for exactly one cycle alongside result. One result per cycle.
// Stage 1 forms the half sums, stages 2 to 4 are three shared-shape
// 129-bit multipliers (high, low and middle), stage 5 subtracts the outer
// products from the middle term and stage 6 assembles the product.
// Reset clears the valid bits only; results in flight are dropped.
// The receiver cannot stall, so results leave as they finish.
module multiply_256x256_karatsuba
    import mk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  operands_t operands,
    output logic      done,
    output product_t  result
);
    localparam int DEPTH = 6;
    localparam int MW = 2*HALF_W + 2;

    logic [DEPTH-1:0] valid_reg;
    logic [HALF_W:0]  ah_reg, al_reg, bh_reg, bl_reg, as_reg, bs_reg;
    logic [MW-1:0]    hh, ll, mm;
    logic [MW-1:0]    hh_reg, ll_reg, mid_reg;
    logic [PROD_W-1:0] prod_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DEPTH-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        al_reg <= {1'b0, operands.a_limb1, operands.a_limb0};
        ah_reg <= {1'b0, operands.a_limb3, operands.a_limb2};
        bl_reg <= {1'b0, operands.b_limb1, operands.b_limb0};
        bh_reg <= {1'b0, operands.b_limb3, operands.b_limb2};
        as_reg <= {1'b0, operands.a_limb1, operands.a_limb0}
                + {1'b0, operands.a_limb3, operands.a_limb2};
        bs_reg <= {1'b0, operands.b_limb1, operands.b_limb0}
                + {1'b0, operands.b_limb3, operands.b_limb2};
    end

    mk_mul129 u_mul_hh (.clk(clk), .x(ah_reg), .y(bh_reg), .p(hh));
    mk_mul129 u_mul_ll (.clk(clk), .x(al_reg), .y(bl_reg), .p(ll));
    mk_mul129 u_mul_mm (.clk(clk), .x(as_reg), .y(bs_reg), .p(mm));

    always_ff @(posedge clk)
    begin
        hh_reg  <= hh;
        ll_reg  <= ll;
        mid_reg <= mm - hh - ll;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {hh_reg[2*HALF_W-1:0], ll_reg[2*HALF_W-1:0]}
                  + (PROD_W'(mid_reg) << HALF_W);
    end

    assign done   = valid_reg[DEPTH-1];
    assign result = prod_reg;
endmodule

>>> src/mk_checker.sv
// Port-level checker for the multiplier, bound to the top level.
// Depends on mk_pkg for the beat types.
module mk_checker
    import mk_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input operands_t operands,
    input logic      done,
    input product_t  result
);
    // Every accepted beat yields a strobe, and a strobe follows only an accepted beat.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##6 done)
        else $error("missing result strobe");
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(rst_n, 6) |-> $past(start, 6))
        else $error("spurious result strobe");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("pipeline reported busy");
    // A zero a operand gives a zero product.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && operands[OPER_W-1:0] == '0 |-> ##6 (result == '0))
        else $error("nonzero product of zero operand");
endmodule

bind multiply_256x256_karatsuba mk_checker u_mk_checker (.*);

>>> bench/multiply_256x256_karatsuba_tb.sv
// Testbench for the 256x256 Karatsuba multiplier: random and corner operands,
// products predicted with a digit-wise schoolbook multiply. Depends on mk_pkg.
`timescale 1ns / 100ps

module multiply_256x256_karatsuba_tb;
    import mk_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BEATS   = 640;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    operands_t operands;
    logic      done;
    product_t  result;

    operands_t pending_operands[$];
    product_t  expected_products[$];
    int        error_count;
    int        quiet_cycles;
    int        driver_gap;
    bit        gaps_enabled;
    bit        hold_until_empty;
    bit        stimulus_done;

    multiply_256x256_karatsuba DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Schoolbook product over 32-bit digits.
    function automatic product_t multiply_operands(operands_t op);
        logic [31:0] xa[8];
        logic [31:0] xb[8];
        logic [31:0] digits[16];
        logic [63:0] acc;
        logic [63:0] carry;
        logic [255:0] a_val;
        logic [255:0] b_val;
        logic [511:0] full;
        a_val = {op.a_limb3, op.a_limb2, op.a_limb1, op.a_limb0};
        b_val = {op.b_limb3, op.b_limb2, op.b_limb1, op.b_limb0};
        for (int i = 0; i < 8; i++)
        begin
            xa[i] = a_val[32*i +: 32];
            xb[i] = b_val[32*i +: 32];
        end
        for (int i = 0; i < 16; i++)
            digits[i] = '0;
        for (int i = 0; i < 8; i++)
        begin
            carry = '0;
            for (int j = 0; j < 8; j++)
            begin
                acc = 64'(xa[i]) * 64'(xb[j]) + 64'(digits[i+j]) + carry;
                digits[i+j] = acc[31:0];
                carry = {32'd0, acc[63:32]};
            end
            digits[i+8] = carry[31:0];
        end
        for (int i = 0; i < 16; i++)
            full[32*i +: 32] = digits[i];
        return product_t'(full);
    endfunction

    function automatic logic [63:0] random_limb();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = 64'(1) << $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    // Driver: one pending beat per accepted edge, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            operands   <= '0;
            driver_gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_products.push_back(multiply_operands(operands));
                void'(pending_operands.pop_front());
            end
            if (driver_gap > 0)
            begin
                driver_gap <= driver_gap - 1;
                start <= 1'b0;
            end
            else if (start && !busy && gaps_enabled && $urandom_range(0, 9) == 0)
            begin
                driver_gap <= $urandom_range(0, 14);
                start <= 1'b0;
            end
            else if (hold_until_empty && expected_products.size() != 0)
                start <= 1'b0;
            else if (start && busy)
                start <= 1'b1;
            else
            begin
                // The accepted beat has already left the queue, so the front is next.
                if (pending_operands.size() != 0)
                begin
                    start    <= 1'b1;
                    operands <= pending_operands[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each product beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("product beat with no expectation: %h", result);
                    error_count++;
                end
                else
                begin
                    product_t exp_p;
                    exp_p = expected_products.pop_front();
                    if (result.product_limb0 !== exp_p.product_limb0)
                    begin
                        $error("product_limb0 exp %h got %h", exp_p.product_limb0,
                               result.product_limb0);
                        error_count++;
                    end
                    if (result.product_limb1 !== exp_p.product_limb1)
                    begin
                        $error("product_limb1 exp %h got %h", exp_p.product_limb1,
                               result.product_limb1);
                        error_count++;
                    end
                    if (result.product_limb2 !== exp_p.product_limb2)
                    begin
                        $error("product_limb2 exp %h got %h", exp_p.product_limb2,
                               result.product_limb2);
                        error_count++;
                    end
                    if (result.product_limb3 !== exp_p.product_limb3)
                    begin
                        $error("product_limb3 exp %h got %h", exp_p.product_limb3,
                               result.product_limb3);
                        error_count++;
                    end
                    if (result.product_limb4 !== exp_p.product_limb4)
                    begin
                        $error("product_limb4 exp %h got %h", exp_p.product_limb4,
                               result.product_limb4);
                        error_count++;
                    end
                    if (result.product_limb5 !== exp_p.product_limb5)
                    begin
                        $error("product_limb5 exp %h got %h", exp_p.product_limb5,
                               result.product_limb5);
                        error_count++;
                    end
                    if (result.product_limb6 !== exp_p.product_limb6)
                    begin
                        $error("product_limb6 exp %h got %h", exp_p.product_limb6,
                               result.product_limb6);
                        error_count++;
                    end
                    if (result.product_limb7 !== exp_p.product_limb7)
                    begin
                        $error("product_limb7 exp %h got %h", exp_p.product_limb7,
                               result.product_limb7);
                        error_count++;
                    end
                end
            end
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        operands_t op;
        error_count      = 0;
        quiet_cycles     = 0;
        gaps_enabled     = 1'b0;
        hold_until_empty = 1'b0;
        stimulus_done    = 1'b0;
        rst_n            = 1'b0;

        // Corner operands: zeros, all ones, single bits, mixed extremes.
        op = '0;
        pending_operands.push_back(op);
        op = '1;
        pending_operands.push_back(op);
        op = '0;
        op.a_limb0 = 64'd1;
        op.b_limb0 = 64'd1;
        pending_operands.push_back(op);
        op = '0;
        op.a_limb3 = 64'h8000_0000_0000_0000;
        op.b_limb3 = 64'h8000_0000_0000_0000;
        pending_operands.push_back(op);
        op = '1;
        op.b_limb0 = '0;
        op.b_limb1 = '0;
        op.b_limb2 = '0;
        op.b_limb3 = '0;
        pending_operands.push_back(op);
        op = '1;
        op.a_limb0 = '0;
        op.a_limb1 = '0;
        pending_operands.push_back(op);
        op = '1;
        op.a_limb2 = '0;
        op.a_limb3 = '0;
        op.b_limb2 = '0;
        op.b_limb3 = '0;
        pending_operands.push_back(op);
        op = {8{64'hAAAA_AAAA_5555_5555}};
        pending_operands.push_back(op);
        op = {8{64'h0000_0000_FFFF_FFFF}};
        pending_operands.push_back(op);
        op = {8{64'hFFFF_FFFF_0000_0000}};
        pending_operands.push_back(op);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_operands.size() == 0);
        gaps_enabled = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            op.a_limb0 = random_limb();
            op.a_limb1 = random_limb();
            op.a_limb2 = random_limb();
            op.a_limb3 = random_limb();
            op.b_limb0 = random_limb();
            op.b_limb1 = random_limb();
            op.b_limb2 = random_limb();
            op.b_limb3 = random_limb();
            pending_operands.push_back(op);
            if (n == RANDOM_BEATS / 2)
            begin
                // Let the pipeline drain fully before sending more.
                wait (pending_operands.size() == 0);
                hold_until_empty = 1'b1;
                wait (expected_products.size() == 0);
                @(posedge clk);
                hold_until_empty = 1'b0;
            end
            if (n == RANDOM_BEATS - 120)
            begin
                wait (pending_operands.size() == 0);
                gaps_enabled = 1'b0;
            end
        end
        wait (pending_operands.size() == 0 && !start);
        wait (expected_products.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        stimulus_done = 1'b1;
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!stimulus_done && quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
